// ===== rtl/cosine_sine_taylor_unit_assert.svh =====
// Assertion macros for the cosine/sine Taylor unit; they expect clk and arst_n in scope.
`ifndef COSINE_SINE_TAYLOR_UNIT_ASSERT_SVH
`define COSINE_SINE_TAYLOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSTU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSTU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cstu_pkg.sv =====
// Types, constants and per-term divider tables for the cosine/sine Taylor unit.
`timescale 1ns / 1ps

package cstu_pkg;

	// Field and datapath widths.
	localparam int unsigned ANGLE_W = 32;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned TC_W    = 3;
	localparam int unsigned A_W     = 39;
	localparam int unsigned MAG_W   = 38;
	localparam int unsigned QUOT_W  = 7;
	localparam int unsigned M_W     = 31;
	localparam int unsigned T_W     = 32;
	localparam int unsigned TERM_W  = 31;
	localparam int unsigned ACC_W   = 34;
	localparam int unsigned PROD_W  = TERM_W + T_W;
	localparam int unsigned Z_W     = 31;
	localparam int unsigned REC_W   = 32;
	localparam int unsigned FRAC_W  = 30;

	// Function selector carried in tuser.
	localparam logic KIND_COS = 1'b0;
	localparam logic KIND_SIN = 1'b1;

	// pi/2 and one in Q30.
	localparam logic [M_W-1:0]    HALF_PI_Q30 = 31'd1686629713;
	localparam logic [TERM_W-1:0] ONE_Q30     = 31'd1073741824;

	typedef logic signed [ACC_W-1:0] acc_t;

	// Payload carried between the series stages.
	typedef struct packed {
		logic [T_W-1:0]    t;
		logic [TERM_W-1:0] term;
		acc_t              acc;
		logic              neg;
	} series_t;

	// Divisor (2k)(2k-1) of series term k.
	function automatic logic [7:0] series_div(input logic [2:0] k);
		logic [7:0] d;
		unique case (k)
			3'd1: d = 8'd2;
			3'd2: d = 8'd12;
			3'd3: d = 8'd30;
			3'd4: d = 8'd56;
			3'd5: d = 8'd90;
			3'd6: d = 8'd132;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

	// Power-of-two factor of the divisor, as a shift.
	function automatic logic [1:0] div_shift(input logic [2:0] k);
		logic [1:0] s;
		unique case (k)
			3'd1: s = 2'd1;
			3'd2: s = 2'd2;
			3'd3: s = 2'd1;
			3'd4: s = 2'd3;
			3'd5: s = 2'd1;
			3'd6: s = 2'd2;
			default: s = 2'd0;
		endcase
		return s;
	endfunction

	// Reciprocal ceil(2^S / o) of the odd factor o, exact for 31-bit dividends.
	function automatic logic [REC_W-1:0] div_recip(input logic [2:0] k);
		logic [REC_W-1:0] r;
		unique case (k)
			3'd1: r = 32'd2147483648;
			3'd2: r = 32'd2863311531;
			3'd3: r = 32'd2290649225;
			3'd4: r = 32'd2454267027;
			3'd5: r = 32'd3054198967;
			3'd6: r = 32'd4164816772;
			default: r = 32'd2147483648;
		endcase
		return r;
	endfunction

	// Right shift S that goes with the reciprocal.
	function automatic logic [5:0] recip_shift(input logic [2:0] k);
		logic [5:0] s;
		unique case (k)
			3'd1: s = 6'd31;
			3'd2: s = 6'd33;
			3'd3: s = 6'd35;
			3'd4: s = 6'd34;
			3'd5: s = 6'd37;
			3'd6: s = 6'd37;
			default: s = 6'd31;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/cosine_sine_taylor_unit.sv =====
// Pipelined fixed-point cosine/sine by quadrant reduction and a cosine Taylor series.
//
//  channel   direction  signals                              beat contents
//  s_*       in         s_tvalid s_tready s_tdata s_tuser    angle Q8.24, kind
//  m_*       out        m_tvalid m_tready m_tdata            value Q2.30
//  cfg_*     in         cfg_wen cfg_wdata                    term_count
//
// One beat is accepted per cycle while the skid stage is empty; the pipeline depth is set
// by the seven quotient stages of the reduction and four stages per series term.
// arst_n clears all valid bits, including those of the output register and the skid stage; term_count resets to 6.
// The pipeline advances whenever the skid stage is empty, so a waiting result does not
// block input until a second result arrives behind it; s_tready is a registered signal.
`timescale 1ns / 1ps
`include "cosine_sine_taylor_unit_assert.svh"

module cosine_sine_taylor_unit #(
	parameter int MAX_TERMS = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [cstu_pkg::ANGLE_W-1:0]       s_tdata,   // [31:0] angle
	input  logic [0:0]                         s_tuser,   // [0] kind
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [cstu_pkg::VALUE_W-1:0]       m_tdata,   // [31:0] value
	input  logic                               cfg_wen,
	input  logic [cstu_pkg::TC_W-1:0]          cfg_wdata  // term_count
);

	logic                        pipe_en;
	logic [cstu_pkg::TC_W-1:0]   tc_q;
	logic [cstu_pkg::TC_W-1:0]   n_eff;

	// Term count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= 3'd6;
		end else if (cfg_wen) begin
			tc_q <= cfg_wdata;
		end
	end

	assign n_eff = (tc_q > cstu_pkg::TC_W'(MAX_TERMS)) ? cstu_pkg::TC_W'(MAX_TERMS) : tc_q;

	// The whole pipeline moves while the skid stage is empty.
	logic skid_vld_q;
	assign pipe_en  = !skid_vld_q;
	assign s_tready = pipe_en;

	// Stage 1: scale to Q30 and shift sine by pi/2.
	logic                                a_vld_s1;
	logic signed [cstu_pkg::A_W-1:0]     a_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_s1 <= 1'b0;
		end else if (pipe_en) begin
			a_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			a_s1 <= $signed({s_tdata[cstu_pkg::ANGLE_W-1], s_tdata, 6'b0})
				- $signed({8'b0, (s_tuser[0] ? cstu_pkg::HALF_PI_Q30 : 31'd0)});
		end
	end

	// Stage 2 is entry 0 of the divider arrays (magnitude); entries 1..7 find one quotient
	// bit each by compare and subtract of pi/2 shifted into place.
	logic                              div_vld_s [cstu_pkg::QUOT_W+1];
	logic [cstu_pkg::MAG_W-1:0]        div_rem_s [cstu_pkg::QUOT_W+1];
	logic [cstu_pkg::QUOT_W-1:0]       div_q_s   [cstu_pkg::QUOT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else if (pipe_en) begin
			div_vld_s[0] <= a_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			div_rem_s[0] <= a_s1[cstu_pkg::A_W-1] ? cstu_pkg::MAG_W'(-a_s1)
				: cstu_pkg::MAG_W'(a_s1);
			div_q_s[0]   <= '0;
		end
	end

	for (genvar j = 1; j <= cstu_pkg::QUOT_W; j++) begin : g_div
		localparam int unsigned BIT = cstu_pkg::QUOT_W - j;
		logic [cstu_pkg::MAG_W-1:0] dvsr;
		logic                       ge;

		assign dvsr = cstu_pkg::MAG_W'(cstu_pkg::HALF_PI_Q30) << BIT;
		assign ge   = (div_rem_s[j-1] >= dvsr);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[j] <= 1'b0;
			end else if (pipe_en) begin
				div_vld_s[j] <= div_vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				div_rem_s[j] <= ge ? (div_rem_s[j-1] - dvsr) : div_rem_s[j-1];
				div_q_s[j]   <= {div_q_s[j-1][cstu_pkg::QUOT_W-2:0], ge};
			end
		end
	end

	// Stage 10: fold odd quadrants and work out the final sign.
	logic                          m_vld_s10;
	logic [cstu_pkg::M_W-1:0]      m_s10;
	logic                          neg_s10;
	logic [cstu_pkg::M_W-1:0]      rem_fin;
	logic [cstu_pkg::QUOT_W-1:0]   quo_fin;
	logic [cstu_pkg::QUOT_W:0]     quo_p3;

	assign rem_fin = cstu_pkg::M_W'(div_rem_s[cstu_pkg::QUOT_W]);
	assign quo_fin = div_q_s[cstu_pkg::QUOT_W];
	assign quo_p3  = {1'b0, quo_fin} + 8'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_s10 <= 1'b0;
		end else if (pipe_en) begin
			m_vld_s10 <= div_vld_s[cstu_pkg::QUOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			m_s10   <= quo_fin[0] ? (cstu_pkg::HALF_PI_Q30 - rem_fin) : rem_fin;
			neg_s10 <= !quo_p3[1];
		end
	end

	// Stage 11 is series entry 0: x^2 in Q30 and the constant first term.
	logic                  ser_vld_s [MAX_TERMS];
	cstu_pkg::series_t     ser_s     [MAX_TERMS];
	logic [2*cstu_pkg::M_W-1:0] m_sq;

	assign m_sq = (2*cstu_pkg::M_W)'(m_s10) * (2*cstu_pkg::M_W)'(m_s10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_s[0] <= 1'b0;
		end else if (pipe_en) begin
			ser_vld_s[0] <= m_vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ser_s[0].t    <= m_sq[cstu_pkg::FRAC_W +: cstu_pkg::T_W];
			ser_s[0].term <= cstu_pkg::ONE_Q30;
			ser_s[0].acc  <= (n_eff != '0) ? cstu_pkg::acc_t'(cstu_pkg::ONE_Q30) : '0;
			ser_s[0].neg  <= neg_s10;
		end
	end

	// Four stages per term: multiply, round and strip the power of two, reciprocal
	// multiply, then add or subtract into the running sum.
	for (genvar k = 1; k < MAX_TERMS; k++) begin : g_term
		localparam logic [2:0]                 KI  = 3'(k);
		localparam logic [7:0]                 DV  = cstu_pkg::series_div(KI);
		localparam logic [1:0]                 DS  = cstu_pkg::div_shift(KI);
		localparam logic [cstu_pkg::REC_W-1:0] RC  = cstu_pkg::div_recip(KI);
		localparam logic [5:0]                 RS  = cstu_pkg::recip_shift(KI);

		logic                               pa_vld_s, pb_vld_s, pc_vld_s;
		logic [cstu_pkg::PROD_W-1:0]        pa_s;
		logic [cstu_pkg::Z_W-1:0]           pb_s;
		logic [cstu_pkg::TERM_W-1:0]        pc_s;
		cstu_pkg::series_t                  pa_c, pb_c, pc_c;
		logic [cstu_pkg::PROD_W:0]          rnd_sum;
		logic [cstu_pkg::T_W-1:0]           y_div;
		logic [cstu_pkg::Z_W+cstu_pkg::REC_W-1:0] rq;
		cstu_pkg::acc_t                     term_ext;

		assign rnd_sum  = {1'b0, pa_s} + ((cstu_pkg::PROD_W+1)'(DV) << (cstu_pkg::FRAC_W - 1));
		assign y_div    = rnd_sum[cstu_pkg::FRAC_W +: cstu_pkg::T_W];
		assign rq       = (cstu_pkg::Z_W+cstu_pkg::REC_W)'(pb_s)
			* (cstu_pkg::Z_W+cstu_pkg::REC_W)'(RC);
		assign term_ext = cstu_pkg::acc_t'(pc_s);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pa_vld_s     <= 1'b0;
				pb_vld_s     <= 1'b0;
				pc_vld_s     <= 1'b0;
				ser_vld_s[k] <= 1'b0;
			end else if (pipe_en) begin
				pa_vld_s     <= ser_vld_s[k-1];
				pb_vld_s     <= pa_vld_s;
				pc_vld_s     <= pb_vld_s;
				ser_vld_s[k] <= pc_vld_s;
			end
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				pa_s <= cstu_pkg::PROD_W'(ser_s[k-1].term) * cstu_pkg::PROD_W'(ser_s[k-1].t);
				pa_c <= ser_s[k-1];
				pb_s <= cstu_pkg::Z_W'(y_div >> DS);
				pb_c <= pa_c;
				pc_s <= cstu_pkg::TERM_W'(rq >> RS);
				pc_c <= pb_c;
				ser_s[k].t    <= pc_c.t;
				ser_s[k].term <= pc_s;
				ser_s[k].neg  <= pc_c.neg;
				if (KI < n_eff) begin
					ser_s[k].acc <= KI[0] ? (pc_c.acc - term_ext) : (pc_c.acc + term_ext);
				end else begin
					ser_s[k].acc <= pc_c.acc;
				end
			end
		end
	end

	// Final stage: apply the sign and saturate to Q2.30.
	logic                              fin_vld_s;
	logic [cstu_pkg::VALUE_W-1:0]      fin_s;
	logic signed [cstu_pkg::ACC_W:0]   sgn_sum;
	logic signed [cstu_pkg::ACC_W:0]   acc_wide;

	assign acc_wide = {ser_s[MAX_TERMS-1].acc[cstu_pkg::ACC_W-1], ser_s[MAX_TERMS-1].acc};
	assign sgn_sum  = ser_s[MAX_TERMS-1].neg ? -acc_wide : acc_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_s <= 1'b0;
		end else if (pipe_en) begin
			fin_vld_s <= ser_vld_s[MAX_TERMS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			priority if (sgn_sum > 35'sd2147483647) begin
				fin_s <= 32'h7FFF_FFFF;
			end else if (sgn_sum < -35'sd2147483648) begin
				fin_s <= 32'h8000_0000;
			end else begin
				fin_s <= cstu_pkg::VALUE_W'(sgn_sum);
			end
		end
	end

	// Output register with a skid stage behind it.
	logic                          out_vld_q;
	logic [cstu_pkg::VALUE_W-1:0]  out_data_q;
	logic [cstu_pkg::VALUE_W-1:0]  skid_data_q;
	logic                          out_free;

	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q  <= fin_vld_s;
			end
		end else if (fin_vld_s && pipe_en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_vld_q ? skid_data_q : fin_s;
		end
		if (!out_free && pipe_en) begin
			skid_data_q <= fin_s;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// Checks on the reduction, the series and the output buffering.
	`CSTU_ASSERT_NOW(a_skid_needs_out, skid_vld_q, out_vld_q, "skid stage full while output is empty")
	`CSTU_ASSERT_NEXT(a_skid_catches, m_tvalid && !m_tready && !skid_vld_q && fin_vld_s, skid_vld_q, "result not caught by the skid stage")
	`CSTU_ASSERT_NEXT(a_skid_drains, m_tvalid && m_tready && skid_vld_q, m_tvalid && !skid_vld_q, "skid stage did not move to the output")
	`CSTU_ASSERT_NOW(a_reduced_range, m_vld_s10, m_s10 <= cstu_pkg::HALF_PI_Q30, "reduced angle above pi/2")
	`CSTU_ASSERT_NOW(a_zero_terms, ser_vld_s[MAX_TERMS-1] && (tc_q == '0), ser_s[MAX_TERMS-1].acc == '0, "nonzero sum with no terms")

endmodule

// ===== tb/cosine_sine_taylor_checker.sv =====
// Checker for the cosine/sine Taylor unit: predicts each result and compares output beats.
`timescale 1ns / 1ps

module cosine_sine_taylor_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [cstu_pkg::ANGLE_W-1:0]  s_tdata,   // [31:0] angle
	input  logic [0:0]                    s_tuser,   // [0] kind
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [cstu_pkg::VALUE_W-1:0]  m_tdata,   // [31:0] value
	input  logic                          cfg_wen,
	input  logic [cstu_pkg::TC_W-1:0]     cfg_wdata,
	output int                            mismatches,
	output int                            outstanding
);

	localparam int                        MAX_TERMS     = 7;
	localparam logic [cstu_pkg::TC_W-1:0] TERMS_AT_RST  = 3'd6;
	localparam longint                    HALF_PI_Q30   = 64'd1686629713;
	localparam longint                    ONE_Q30       = 64'd1073741824;

	logic [cstu_pkg::TC_W-1:0]  term_count = TERMS_AT_RST;
	logic [cstu_pkg::VALUE_W-1:0] expected_values [$];

	// Reduce the angle to a quadrant, sum the cosine series and fix the sign.
	function automatic logic [cstu_pkg::VALUE_W-1:0] taylor_value(
		input logic kind,
		input logic [cstu_pkg::ANGLE_W-1:0] angle,
		input logic [cstu_pkg::TC_W-1:0] nterms
	);
		longint          shifted;
		longint          acc;
		longint unsigned mag;
		longint unsigned quad;
		longint unsigned rem;
		longint unsigned m;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned divisor;
		int              n;
		shifted = longint'($signed(angle)) * 64;
		if (kind == cstu_pkg::KIND_SIN)
			shifted = shifted - HALF_PI_Q30;
		mag = (shifted < 0) ? longint'(-shifted) : longint'(shifted);
		quad = mag / HALF_PI_Q30;
		rem = mag % HALF_PI_Q30;
		m = quad[0] ? HALF_PI_Q30 - rem : rem;
		x2 = (m * m) >> 30;
		n = (int'(nterms) > MAX_TERMS) ? MAX_TERMS : int'(nterms);
		term = ONE_Q30;
		acc = 0;
		for (int k = 0; k < n; k++) begin
			if (k > 0) begin
				// Each step divides by (2k)(2k-1) in Q30, rounded to nearest.
				divisor = longint'((2 * k) * (2 * k - 1)) << 30;
				term = (term * x2 + (divisor >> 1)) / divisor;
			end
			if (k % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if ((((quad + 3) >> 1) & 1) == 0)
			acc = -acc;
		if (acc > 64'sd2147483647)
			acc = 64'sd2147483647;
		else if (acc < -64'sd2147483648)
			acc = -64'sd2147483648;
		return acc[cstu_pkg::VALUE_W-1:0];
	endfunction

	// Track the register, queue a prediction per input beat and check each output beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count = TERMS_AT_RST;
			expected_values.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			if (cfg_wen)
				term_count = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (expected_values.size() == 0) begin
					$error("value: no result expected, got %h", m_tdata);
					mismatches = mismatches + 1;
				end else begin
					if (m_tdata !== expected_values[0]) begin
						$error("value: expected %h, got %h", expected_values[0], m_tdata);
						mismatches = mismatches + 1;
					end
					void'(expected_values.pop_front());
				end
			end
			if (s_tvalid && s_tready)
				expected_values = {expected_values,
					taylor_value(s_tuser[0], s_tdata, term_count)};
			outstanding = expected_values.size();
		end
	end

endmodule

// ===== tb/cosine_sine_taylor_unit_tb.sv =====
// Testbench top for the cosine/sine Taylor unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module cosine_sine_taylor_unit_tb;

	localparam int CYCLE_LIMIT       = 200000;
	localparam int PIPE_LATENCY      = 40;
	localparam int BEATS_PER_PHASE   = 45;
	localparam int PHASES            = 9;
	localparam int QUARTER_TURN_Q24  = 26353589;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [cstu_pkg::ANGLE_W-1:0]  s_tdata;   // [31:0] angle
	logic [0:0]                    s_tuser;   // [0] kind
	logic                          m_tvalid;
	logic                          m_tready;
	logic [cstu_pkg::VALUE_W-1:0]  m_tdata;   // [31:0] value
	logic                          cfg_wen;
	logic [cstu_pkg::TC_W-1:0]     cfg_wdata;

	int   mismatches;
	int   outstanding;
	int   cycles = 0;
	int   stall_left = 0;
	logic calm = 1'b0;

	// Angles at the range limits, at zero and on quadrant boundaries.
	logic [31:0] corner_angles [12] = '{
		32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
		32'h8000_0000, 32'd26353589, 32'd26353590, 32'd52707179,
		-32'sd52707179, 32'd79060768, 32'd1686629713, -32'sd1686629713
	};

	// Term counts per phase; the first phase keeps the reset value.
	int term_plan [PHASES] = '{6, 0, 7, 1, 2, 3, 4, 5, 6};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	cosine_sine_taylor_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	cosine_sine_taylor_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver backpressure: random stall bursts, none once the run turns calm.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 14);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Present one beat, with an optional idle burst first, and wait for its acceptance.
	task automatic send_beat(input logic kind, input logic [31:0] angle);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= angle;
		s_tuser <= kind;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Let every result drain, then write the term count while the unit is idle.
	task automatic set_term_count(input int count);
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (PIPE_LATENCY) @(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= count[cstu_pkg::TC_W-1:0];
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Mix of full-range, near-origin and quadrant-boundary angles.
	function automatic logic [31:0] pick_angle();
		int offset;
		int base;
		offset = $urandom_range(0, 128) - 64;
		base = $urandom_range(0, 80) * QUARTER_TURN_Q24;
		case ($urandom_range(0, 3))
			0, 1: return $urandom;
			2: return $urandom_range(0, 240000000) - 120000000;
			default: return ($urandom_range(0, 1) == 1) ? -(base + offset) : base + offset;
		endcase
	endfunction

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_wen <= 1'b0;
		cfg_wdata <= '0;
		m_tready <= 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed corners, both functions, at the reset term count.
		foreach (corner_angles[i]) begin
			send_beat(cstu_pkg::KIND_COS, corner_angles[i]);
			send_beat(cstu_pkg::KIND_SIN, corner_angles[i]);
		end

		// Random phases over the term counts; the last phase runs without idling.
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0)
				set_term_count(term_plan[p]);
			if (p == PHASES - 1)
				calm = 1'b1;
			repeat (BEATS_PER_PHASE)
				send_beat(1'($urandom_range(0, 1)), pick_angle());
		end

		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (PIPE_LATENCY) @(negedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cstu_pkg.sv
rtl/cosine_sine_taylor_unit.sv
tb/cosine_sine_taylor_checker.sv
tb/cosine_sine_taylor_unit_tb.sv
